>>> src/text_console_renderer_core_macros.svh
// Assertion macros shared by the text console renderer RTL.
`ifndef TEXT_CONSOLE_RENDERER_CORE_MACROS_SVH
`define TEXT_CONSOLE_RENDERER_CORE_MACROS_SVH

// Check a property while out of reset.
`define TCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define TCR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/tcr_pkg.sv
// Shared types and constants of the text console renderer.
package tcr_pkg;

    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 11;
    localparam int CELL_W    = 16;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;

    typedef struct packed {
        logic [BYTE_W-1:0] escape_code;
        logic [BYTE_W-1:0] clear_code;
        logic [BYTE_W-1:0] color_code;
        logic [BYTE_W-1:0] set_row_code;
        logic [BYTE_W-1:0] set_col_code;
    } t_cfg;

    typedef struct packed {
        logic take;
        logic exec;
        logic load_out;
        logic cnt_zero;
        logic cnt_row;
        logic cnt_inc;
        logic stage_fill;
        logic stage_copy;
    } t_cmd;

    typedef struct packed {
        logic need_clear;
        logic need_scroll;
        logic cnt_last;
        logic copy_last;
        logic wr_busy;
    } t_stat;

endpackage

>>> src/tcr_ctrl.sv
// Sequencer of the text console renderer: request flow, sweeps and result handshake.
module tcr_ctrl
    import tcr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_valid,
    output logic  o_s_ready,
    input  logic  i_m_ready,
    output logic  o_m_valid,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_CLEAR,
        S_COPY,
        S_FILL,
        S_RESULT
    } t_state;

    t_state r_state;
    logic   r_ovalid;
    logic   w_accept;
    logic   w_out_free;

    assign o_s_ready  = (r_state == S_IDLE) && !i_stat.wr_busy;
    assign w_accept   = i_s_valid && o_s_ready;
    assign w_out_free = !r_ovalid || i_m_ready;
    assign o_m_valid  = r_ovalid;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_INIT, S_CLEAR, S_FILL: begin
                o_cmd.stage_fill = 1'b1;
                if (i_stat.cnt_last) begin
                    o_cmd.cnt_zero = 1'b1;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_COPY: begin
                o_cmd.stage_copy = 1'b1;
                if (i_stat.copy_last) begin
                    o_cmd.cnt_row = 1'b1;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_IDLE: begin
                o_cmd.take = w_accept;
            end
            S_EXEC: begin
                o_cmd.exec     = 1'b1;
                o_cmd.load_out = !i_stat.need_clear && !i_stat.need_scroll && w_out_free;
            end
            S_RESULT: begin
                o_cmd.load_out = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ovalid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    if (i_stat.cnt_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    priority if (i_stat.need_clear) begin
                        r_state <= S_CLEAR;
                    end else if (i_stat.need_scroll) begin
                        r_state <= S_COPY;
                    end else if (w_out_free) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_RESULT;
                    end
                end
                S_CLEAR, S_FILL: begin
                    if (i_stat.cnt_last) begin
                        r_state <= S_RESULT;
                    end
                end
                S_COPY: begin
                    if (i_stat.copy_last) begin
                        r_state <= S_FILL;
                    end
                end
                S_RESULT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

endmodule

>>> src/tcr_dpath.sv
// Datapath of the text console renderer: screen memory, cursor, parser and result register.
module tcr_dpath
    import tcr_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  t_cfg                 i_cfg,
    input  logic                 i_req,
    input  logic [BYTE_W-1:0]    i_byte,
    input  logic                 i_eow,
    input  logic [IDX_W-1:0]     i_idx,
    output logic                 o_printed,
    output logic [CELL_W-1:0]    o_cell,
    output logic [ROW_OUT_W-1:0] o_row,
    output logic [COL_OUT_W-1:0] o_col
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int COPY_N = (ROWS - 1) * COLUMNS;
    localparam int AW     = $clog2(CELLS);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLUMNS);
    localparam int RXW    = RW + 1;
    localparam int CXW    = $clog2(COLUMNS + TAB_WIDTH);
    localparam int NBYTES = 1 << BYTE_W;

    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h07;

    typedef enum logic [2:0] {
        PH_NORMAL,
        PH_ESC,
        PH_ATTR,
        PH_ROW,
        PH_COL
    } t_phase;

    // constant lookup tables
    logic [RW-1:0]  w_row_mod [NBYTES];
    logic [CW-1:0]  w_col_mod [NBYTES];
    logic [CXW-1:0] w_tab_next [COLUMNS];

    for (genvar g = 0; g < NBYTES; g++) begin : g_mod
        localparam int RM = g % ROWS;
        localparam int CM = g % COLUMNS;
        assign w_row_mod[g] = RW'(RM);
        assign w_col_mod[g] = CW'(CM);
    end

    for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
        localparam int TN = (g / TAB_WIDTH) * TAB_WIDTH + TAB_WIDTH;
        assign w_tab_next[g] = CXW'(TN);
    end

    // state
    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdata;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic [BYTE_W-1:0] r_attr;
    t_phase            r_phase;
    logic [AW-1:0]     r_cnt;
    logic              r_wv;
    logic [AW-1:0]     r_wa;
    logic              r_wfill;

    logic              r_req;
    logic [BYTE_W-1:0] r_byte;
    logic              r_eow;
    logic [IDX_W-1:0]  r_idx;
    logic              r_printed;
    logic [CELL_W-1:0] r_cell;

    logic                 r_out_printed;
    logic [CELL_W-1:0]    r_out_cell;
    logic [ROW_OUT_W-1:0] r_out_row;
    logic [COL_OUT_W-1:0] r_out_col;

    // next values
    logic [RW-1:0]     n_row;
    logic [CW-1:0]     n_col;
    logic [BYTE_W-1:0] n_attr;
    t_phase            n_phase;
    logic              n_printed;
    logic [CELL_W-1:0] n_cell;

    logic [RXW-1:0]    w_rowx;
    logic [CXW-1:0]    w_colx;
    logic              w_put_wr;
    logic              w_put_scroll;
    logic              w_do_put;
    logic              w_clear;
    logic              w_wr;
    logic [AW-1:0]     w_put_addr;
    logic [AW-1:0]     w_raddr;

    assign w_put_addr = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
    assign w_raddr    = i_cmd.stage_copy ? (r_cnt + AW'(COLUMNS)) : AW'(i_idx);

    // cursor motion of one put
    always_comb begin
        w_rowx       = RXW'(r_row);
        w_colx       = CXW'(r_col);
        w_put_wr     = 1'b0;
        w_put_scroll = 1'b0;
        priority if (r_byte == CH_CR) begin
            w_colx = '0;
        end else if (r_byte == CH_LF) begin
            w_colx = '0;
            w_rowx = w_rowx + RXW'(1);
        end else if (r_byte == CH_TAB) begin
            w_colx = w_tab_next[r_col];
        end else begin
            w_colx   = w_colx + CXW'(1);
            w_put_wr = 1'b1;
        end
        if (w_colx >= CXW'(COLUMNS)) begin
            w_colx = '0;
            w_rowx = w_rowx + RXW'(1);
        end
        if (w_rowx >= RXW'(ROWS)) begin
            w_rowx       = RXW'(ROWS - 1);
            w_put_scroll = 1'b1;
        end
    end

    // parser
    always_comb begin
        n_row     = r_row;
        n_col     = r_col;
        n_attr    = r_attr;
        n_phase   = r_phase;
        n_printed = 1'b0;
        n_cell    = '0;
        w_do_put  = 1'b0;
        w_clear   = 1'b0;
        if (r_req) begin
            if (32'(r_idx) < 32'(CELLS)) begin
                n_cell = r_rdata;
            end
        end else begin
            n_phase = PH_NORMAL;
            unique case (r_phase)
                PH_ESC: begin
                    priority if (r_byte == i_cfg.clear_code) begin
                        w_clear = 1'b1;
                        n_row   = '0;
                        n_col   = '0;
                    end else if (r_byte == i_cfg.color_code) begin
                        n_phase = PH_ATTR;
                    end else if (r_byte == i_cfg.set_row_code) begin
                        n_phase = PH_ROW;
                    end else if (r_byte == i_cfg.set_col_code) begin
                        n_phase = PH_COL;
                    end else begin
                        w_do_put = 1'b1;
                    end
                end
                PH_ATTR: begin
                    n_attr = r_byte;
                end
                PH_ROW: begin
                    n_row = w_row_mod[r_byte];
                end
                PH_COL: begin
                    n_col = w_col_mod[r_byte];
                end
                default: begin
                    if (r_byte == i_cfg.escape_code) begin
                        n_phase = PH_ESC;
                    end else begin
                        w_do_put = 1'b1;
                    end
                end
            endcase
            if (w_do_put) begin
                n_row     = RW'(w_rowx);
                n_col     = CW'(w_colx);
                n_printed = 1'b1;
            end
            if (r_eow) begin
                n_phase = PH_NORMAL;
            end
        end
    end

    assign w_wr = w_do_put && w_put_wr;

    assign o_stat.need_clear  = w_clear;
    assign o_stat.need_scroll = w_do_put && w_put_scroll;
    assign o_stat.cnt_last    = (r_cnt == AW'(CELLS - 1));
    assign o_stat.copy_last   = (r_cnt == AW'(COPY_N - 1));
    assign o_stat.wr_busy     = r_wv;

    // screen memory
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_raddr];
        priority if (i_cmd.exec && w_wr) begin
            r_mem[w_put_addr] <= {r_attr, r_byte};
        end else if (r_wv) begin
            r_mem[r_wa] <= r_wfill ? {r_attr, {BYTE_W{1'b0}}} : r_rdata;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_attr  <= ATTR_RESET;
            r_phase <= PH_NORMAL;
            r_cnt   <= '0;
            r_wv    <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_row   <= n_row;
                r_col   <= n_col;
                r_attr  <= n_attr;
                r_phase <= n_phase;
            end
            priority if (i_cmd.cnt_zero) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_row) begin
                r_cnt <= AW'(COPY_N);
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + AW'(1);
            end
            r_wv <= i_cmd.stage_fill || i_cmd.stage_copy;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_wa    <= r_cnt;
        r_wfill <= i_cmd.stage_fill;
        if (i_cmd.take) begin
            r_req  <= i_req;
            r_byte <= i_byte;
            r_eow  <= i_eow;
            r_idx  <= i_idx;
        end
        if (i_cmd.exec) begin
            r_printed <= n_printed;
            r_cell    <= n_cell;
        end
        if (i_cmd.load_out) begin
            if (i_cmd.exec) begin
                r_out_printed <= n_printed;
                r_out_cell    <= n_cell;
                r_out_row     <= ROW_OUT_W'(n_row);
                r_out_col     <= COL_OUT_W'(n_col);
            end else begin
                r_out_printed <= r_printed;
                r_out_cell    <= r_cell;
                r_out_row     <= ROW_OUT_W'(r_row);
                r_out_col     <= COL_OUT_W'(r_col);
            end
        end
    end

    assign o_printed = r_out_printed;
    assign o_cell    = r_out_cell;
    assign o_row     = r_out_row;
    assign o_col     = r_out_col;

endmodule

>>> src/text_console_renderer_core.sv
// Top level of the text console renderer: stream ports, register file and core.
// Plain bytes and cell reads: taken in IDLE, result registered in EXEC, or in RESULT on a stall.
// A new request waits until the last one is done; one memory write per cycle at most.
// Clear blank-fills every cell; scroll copies the rows up, then blank-fills the last row.
// Reset: sync active low; a clearing pass over all cells blocks input.
// Registers return to their defaults on reset and stay writable during the pass.
`include "text_console_renderer_core_macros.svh"

module text_console_renderer_core
    import tcr_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: data_byte[7:0], cell_index[18:8], zero pad[23:19]
    input  logic [23:0] s_axis_tdata,
    // tuser: req_type
    input  logic        s_axis_tuser,
    // tlast: end_of_write
    input  logic        s_axis_tlast,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: cell_data[15:0], cursor_row[20:16], cursor_col[27:21], zero pad[31:28]
    output logic [31:0] m_axis_tdata,
    // tuser: printed
    output logic        m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] REG_ESCAPE  = 3'd0;
    localparam logic [2:0] REG_CLEAR   = 3'd1;
    localparam logic [2:0] REG_COLOR   = 3'd2;
    localparam logic [2:0] REG_SET_ROW = 3'd3;
    localparam logic [2:0] REG_SET_COL = 3'd4;
    localparam int OUT_PAD = 32 - CELL_W - ROW_OUT_W - COL_OUT_W;

    t_cfg  r_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    logic                 w_printed;
    logic [CELL_W-1:0]    w_cell;
    logic [ROW_OUT_W-1:0] w_row;
    logic [COL_OUT_W-1:0] w_col;
    logic                 w_cfg_wr;
    logic [2:0]           w_reg;

    assign pready   = 1'b1;
    assign w_reg    = paddr[4:2];
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.escape_code  <= 8'd27;
            r_cfg.clear_code   <= 8'd99;
            r_cfg.color_code   <= 8'd109;
            r_cfg.set_row_code <= 8'd121;
            r_cfg.set_col_code <= 8'd120;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                REG_ESCAPE:  r_cfg.escape_code  <= pwdata[BYTE_W-1:0];
                REG_CLEAR:   r_cfg.clear_code   <= pwdata[BYTE_W-1:0];
                REG_COLOR:   r_cfg.color_code   <= pwdata[BYTE_W-1:0];
                REG_SET_ROW: r_cfg.set_row_code <= pwdata[BYTE_W-1:0];
                REG_SET_COL: r_cfg.set_col_code <= pwdata[BYTE_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_ESCAPE:  prdata = 32'(r_cfg.escape_code);
            REG_CLEAR:   prdata = 32'(r_cfg.clear_code);
            REG_COLOR:   prdata = 32'(r_cfg.color_code);
            REG_SET_ROW: prdata = 32'(r_cfg.set_row_code);
            REG_SET_COL: prdata = 32'(r_cfg.set_col_code);
            default:     prdata = '0;
        endcase
    end

    tcr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (w_cmd),
        .i_stat    (w_stat)
    );

    tcr_dpath #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .i_cfg     (r_cfg),
        .i_req     (s_axis_tuser),
        .i_byte    (s_axis_tdata[BYTE_W-1:0]),
        .i_eow     (s_axis_tlast),
        .i_idx     (s_axis_tdata[BYTE_W +: IDX_W]),
        .o_printed (w_printed),
        .o_cell    (w_cell),
        .o_row     (w_row),
        .o_col     (w_col)
    );

    assign m_axis_tuser = w_printed;
    assign m_axis_tdata = {{OUT_PAD{1'b0}}, w_col, w_row, w_cell};

    `TCR_ASSERT(a_busy_after_take, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken while busy")
    `TCR_ASSERT(a_one_write_port, w_cmd.exec |-> !w_stat.wr_busy, "cell write collides with sweep write")
    `TCR_ASSERT(a_no_overwrite, w_cmd.load_out |-> !m_axis_tvalid || m_axis_tready, "result overwritten")
    `TCR_ASSERT_ALWAYS(a_reset_blocks_input, !i_rst_n |=> !s_axis_tready, "input open during clearing pass")

endmodule
